[sv/u8dec_pkg.sv]
package u8dec_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_CONT,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_BAD
    } byte_kind_t;

    // one classified input byte on its way from the front to the back
    typedef struct packed {
        byte_kind_t  kind;
        logic [7:0]  data_byte;
        logic        end_of_buffer;
    } token_t;

    function automatic byte_kind_t classify(input logic [7:0] b);
        byte_kind_t k;
        if (b[7] == 1'b0) begin
            k = KIND_ASCII;
        end else if (b[7:6] == 2'b10) begin
            k = KIND_CONT;
        end else if (b[7:5] == 3'b110) begin
            k = KIND_LEAD2;
        end else if (b[7:4] == 4'b1110) begin
            k = KIND_LEAD3;
        end else if (b[7:3] == 5'b11110) begin
            k = KIND_LEAD4;
        end else begin
            k = KIND_BAD;
        end
        return k;
    endfunction

endpackage

[sv/u8dec_front.sv]
module u8dec_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_end_of_buffer,
    input  logic              q_full,
    output logic              q_push,
    output u8dec_pkg::token_t q_token
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_token.kind          = u8dec_pkg::classify(s_data_byte);
        q_token.data_byte     = s_data_byte;
        q_token.end_of_buffer = s_end_of_buffer;
    end

endmodule

[sv/u8dec_queue.sv]
module u8dec_queue #(
    parameter int DEPTH = u8dec_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  u8dec_pkg::token_t push_token,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output u8dec_pkg::token_t head_token
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    u8dec_pkg::token_t entry_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_token = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        // pointers wrap at DEPTH, which need not be a power of two
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

[sv/u8dec_back.sv]
module u8dec_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  u8dec_pkg::token_t q_token,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_code_unit,
    output logic              m_error,
    output logic              m_last
);

    logic [1:0]  bytes_pending_reg, bytes_pending_next;
    logic [15:0] partial_char_reg, partial_char_next;
    logic        discarding_reg, discarding_next;

    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_code_unit_reg;
    logic        m_error_reg;
    logic        m_last_reg;

    logic [1:0]  pend_upd;
    logic [15:0] part_upd;
    logic        disc_upd;
    logic        has_res;
    logic [15:0] res_unit;
    logic        res_err;
    logic        res_last;
    logic [15:0] cont_bits;
    logic [15:0] merged;
    logic        eob;

    assign eob       = q_token.end_of_buffer;
    assign cont_bits = {10'd0, q_token.data_byte[5:0]};
    // first of two continuation bytes lands in bits 11:6
    assign merged    = partial_char_reg |
                       ((bytes_pending_reg == 2'd2) ? (cont_bits << 6) : cont_bits);

    always_comb begin
        pend_upd = bytes_pending_reg;
        part_upd = partial_char_reg;
        disc_upd = discarding_reg;
        has_res  = 1'b0;
        res_unit = '0;
        res_err  = 1'b0;
        res_last = 1'b0;
        if (discarding_reg) begin
            if (eob) begin
                disc_upd = 1'b0;
            end
        end else if (bytes_pending_reg != 2'd0) begin
            pend_upd = bytes_pending_reg - 1'b1;
            part_upd = merged;
            if (bytes_pending_reg == 2'd1) begin
                has_res  = 1'b1;
                res_unit = merged;
                res_last = eob;
                pend_upd = '0;
                part_upd = '0;
            end else if (eob) begin
                // cut off mid-sequence
                has_res  = 1'b1;
                res_err  = 1'b1;
                res_last = 1'b1;
                pend_upd = '0;
                part_upd = '0;
            end
        end else begin
            case (q_token.kind)
                u8dec_pkg::KIND_ASCII: begin
                    has_res  = 1'b1;
                    res_unit = {8'd0, q_token.data_byte};
                    res_last = eob;
                end
                u8dec_pkg::KIND_LEAD2: begin
                    if (eob) begin
                        has_res  = 1'b1;
                        res_err  = 1'b1;
                        res_last = 1'b1;
                    end else begin
                        pend_upd = 2'd1;
                        part_upd = {5'd0, q_token.data_byte[4:0], 6'd0};
                    end
                end
                u8dec_pkg::KIND_LEAD3: begin
                    if (eob) begin
                        has_res  = 1'b1;
                        res_err  = 1'b1;
                        res_last = 1'b1;
                    end else begin
                        pend_upd = 2'd2;
                        part_upd = {q_token.data_byte[3:0], 12'd0};
                    end
                end
                default: begin
                    // four-byte form, stray continuation or invalid lead
                    has_res  = 1'b1;
                    res_err  = 1'b1;
                    res_last = 1'b1;
                    disc_upd = !eob;
                end
            endcase
        end
    end

    assign q_pop = q_valid && (!has_res || !m_valid_reg || m_ready);

    always_comb begin
        bytes_pending_next = q_pop ? pend_upd : bytes_pending_reg;
        partial_char_next  = q_pop ? part_upd : partial_char_reg;
        discarding_next    = q_pop ? disc_upd : discarding_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        if (q_pop && has_res) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_pending_reg <= '0;
            partial_char_reg  <= '0;
            discarding_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            bytes_pending_reg <= bytes_pending_next;
            partial_char_reg  <= partial_char_next;
            discarding_reg    <= discarding_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && has_res) begin
            m_code_unit_reg <= res_unit;
            m_error_reg     <= res_err;
            m_last_reg      <= res_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_code_unit = m_code_unit_reg;
    assign m_error     = m_error_reg;
    assign m_last      = m_last_reg;

    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_pending_reg != 2'd3)
        else $error("bytes_pending out of range");

    a_discard_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        discarding_reg |-> (bytes_pending_reg == 2'd0 && partial_char_reg == 16'd0))
        else $error("discarding with a partial character held");

    a_error_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_error_reg) |-> (m_last_reg && m_code_unit_reg == 16'd0))
        else $error("error result not zero and last");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_code_unit_reg)))
        else $error("pending result overwritten");

endmodule

[sv/utf8_to_ucs2_stream_decoder_top.sv]
// UTF-8 to UCS-2 stream decoder.
// Input channel (s_*): one UTF-8 byte per request, s_end_of_buffer marks the
// last byte of a buffer. Output channel (m_*): one 16-bit code unit per
// completed 1-, 2- or 3-byte character. Invalid leads, 4-byte leads, stray
// continuation bytes and sequences cut off by the end of the buffer give one
// request with m_error and m_last set and a zero code unit; after such an
// error not on the final byte, bytes are dropped up to and including the
// end-of-buffer byte. Throughput: one byte per cycle while the queue is not
// full. Bytes are classified on entry and held in a small queue (QUEUE_DEPTH
// entries); the assembler pops one per cycle unless the byte would give a
// result while the previous one still waits for m_ready. A byte is written
// into the queue, then popped, and the result it completes is registered.
// Reset: aresetn low clears the queue, the assembler state and m_valid.
// Stall: while m_ready is low the result holds; bytes that produce no result
// still drain, and s_ready drops only once the queue is full.
module utf8_to_ucs2_stream_decoder_top #(
    parameter int QUEUE_DEPTH = u8dec_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_error,
    output logic        m_last
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    u8dec_pkg::token_t push_token;
    u8dec_pkg::token_t head_token;

    u8dec_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_buffer (s_end_of_buffer),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_token         (push_token)
    );

    u8dec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_token (push_token),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_token (head_token)
    );

    u8dec_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_token     (head_token),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_unit (m_code_unit),
        .m_error     (m_error),
        .m_last      (m_last)
    );

endmodule
